// ===== hw/rtl/mpq_pkg.sv =====
// Shared constants, codes and types for the max-priority task queue.
// Used by mpq_cell and max_priority_task_queue_core; depends on nothing else.
package mpq_pkg;

    // Built depth of the cell row and field widths
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRIO_W = 32;
    localparam int TAG_W  = 16;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request operation codes
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    // Best-so-far record handed from cell to cell during a scan
    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
        logic [IDX_W-1:0]         idx;
    } t_best;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;   // take the new request's entry
        logic shift;  // take the upper neighbor's entry
        logic scan;   // advance the max scan one stage
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/mpq_cell.sv =====
// One queue cell: holds an entry and one stage of the max-scan chain.
// Depends on mpq_pkg for widths and the t_best / t_cell_ctrl types.
module mpq_cell (
    input  logic                             i_clk,
    input  logic [mpq_pkg::IDX_W-1:0]        i_index,
    input  logic [mpq_pkg::CNT_W-1:0]        i_count,
    input  mpq_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [mpq_pkg::PRIO_W-1:0] i_new_prio,
    input  logic [mpq_pkg::TAG_W-1:0]        i_new_tag,
    input  logic signed [mpq_pkg::PRIO_W-1:0] i_nbr_prio,
    input  logic [mpq_pkg::TAG_W-1:0]        i_nbr_tag,
    input  mpq_pkg::t_best                   i_best,
    output logic signed [mpq_pkg::PRIO_W-1:0] o_prio,
    output logic [mpq_pkg::TAG_W-1:0]        o_tag,
    output mpq_pkg::t_best                   o_best
);
    import mpq_pkg::*;

    logic signed [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]         r_tag;
    t_best                    r_best;
    logic                     w_occupied;
    logic                     w_take;

    // Hold the entry: load a new one or shift down from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prio <= i_new_prio;
            r_tag  <= i_new_tag;
        end else if (i_ctrl.shift) begin
            r_prio <= i_nbr_prio;
            r_tag  <= i_nbr_tag;
        end
    end

    // Take over the best record only on a strictly greater priority,
    // so the earliest entry wins a tie
    assign w_occupied = CNT_W'(i_index) < i_count;
    assign w_take     = w_occupied && (!i_best.valid || (r_prio > i_best.prio));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan) begin
            if (w_take) begin
                r_best.valid <= 1'b1;
                r_best.prio  <= r_prio;
                r_best.tag   <= r_tag;
                r_best.idx   <= i_index;
            end else begin
                r_best <= i_best;
            end
        end
    end

    assign o_prio = r_prio;
    assign o_tag  = r_tag;
    assign o_best = r_best;

endmodule

// ===== hw/rtl/max_priority_task_queue_core.sv =====
// Max-priority task queue: a row of DEPTH cells in arrival order.
// A request is accepted in idle; the scan state then runs the max scan
// through the cell chain, and the done state loads the result register
// once it is free. No new request is taken until that hand-over.
// Reset (synchronous, active low) empties the queue and sets capacity to 16.
module max_priority_task_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpq_pkg::CAP_W-1:0]         i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic signed [mpq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic [mpq_pkg::TAG_W-1:0]         i_task_tag,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_ok,
    output logic [mpq_pkg::CNT_W-1:0]         o_entry_count,
    output logic                              o_is_empty_flag,
    output logic                              o_is_full_flag,
    output logic                              o_top_valid,
    output logic [mpq_pkg::TAG_W-1:0]         o_top_tag,
    output logic signed [mpq_pkg::PRIO_W-1:0] o_top_priority
);
    import mpq_pkg::*;

    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   w_eff_cap;
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ok, n_ok;
    logic [IDX_W-1:0]   r_scan_cnt, n_scan_cnt;
    logic [IDX_W-1:0]   r_top_idx, n_top_idx;
    logic               w_accept, w_add_ok, w_rem_ok, w_out_free;
    logic               w_do_load, w_do_shift, w_scan_en, w_out_load;

    logic                     r_out_valid;
    logic                     r_out_ok;
    logic [CNT_W-1:0]         r_out_count;
    logic                     r_out_empty;
    logic                     r_out_full;
    logic                     r_out_top_valid;
    logic [TAG_W-1:0]         r_out_tag;
    logic signed [PRIO_W-1:0] r_out_prio;

    logic signed [PRIO_W-1:0] w_prio [DEPTH];
    logic [TAG_W-1:0]         w_tag  [DEPTH];
    t_best                    w_best [DEPTH];
    t_best                    w_best_last;

    // Capacity register, saturated to the built depth
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    assign w_eff_cap = (r_cap > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(r_cap);

    // Request decode
    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_add_ok   = (i_func == FUNC_ADD) && (r_count < w_eff_cap);
    assign w_rem_ok   = (i_func == FUNC_COMPLETE) && (r_count != '0);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_best_last = w_best[DEPTH-1];

    // Sequencer: update cells, scan the chain, hand the result over
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ok       = r_ok;
        n_scan_cnt = r_scan_cnt;
        n_top_idx  = r_top_idx;
        w_do_load  = 1'b0;
        w_do_shift = 1'b0;
        w_scan_en  = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_do_load  = w_add_ok;
                    w_do_shift = w_rem_ok;
                    n_ok       = w_add_ok || w_rem_ok;
                    if (w_add_ok) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (w_rem_ok) begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_scan_cnt = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_scan_en  = 1'b1;
                n_scan_cnt = r_scan_cnt + IDX_W'(1);
                if (r_scan_cnt == IDX_W'(DEPTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_top_idx  = w_best_last.idx;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_ok       <= 1'b0;
            r_scan_cnt <= '0;
            r_top_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ok       <= n_ok;
            r_scan_cnt <= n_scan_cnt;
            r_top_idx  <= n_top_idx;
        end
    end

    // Cell row: entries shift down toward cell 0, best record moves up
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctrl               w_ctrl;
        t_best                    w_best_in;
        logic signed [PRIO_W-1:0] w_nbr_prio;
        logic [TAG_W-1:0]         w_nbr_tag;

        assign w_ctrl.load  = w_do_load && (CNT_W'(gi) == r_count);
        assign w_ctrl.scan  = w_scan_en;

        if (gi == 0) begin : g_first
            assign w_best_in = '0;
        end else begin : g_chain
            assign w_best_in = w_best[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_ctrl.shift = 1'b0;
            assign w_nbr_prio   = w_prio[gi];
            assign w_nbr_tag    = w_tag[gi];
        end else begin : g_mid
            assign w_ctrl.shift = w_do_shift && (IDX_W'(gi) >= r_top_idx);
            assign w_nbr_prio   = w_prio[gi+1];
            assign w_nbr_tag    = w_tag[gi+1];
        end

        mpq_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(gi)),
            .i_count    (r_count),
            .i_ctrl     (w_ctrl),
            .i_new_prio (i_priority_req),
            .i_new_tag  (i_task_tag),
            .i_nbr_prio (w_nbr_prio),
            .i_nbr_tag  (w_nbr_tag),
            .i_best     (w_best_in),
            .o_prio     (w_prio[gi]),
            .o_tag      (w_tag[gi]),
            .o_best     (w_best[gi])
        );
    end

    // Result register: hold until taken, next request proceeds meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ok        <= r_ok;
            r_out_count     <= r_count;
            r_out_empty     <= (r_count == '0);
            r_out_full      <= (r_count >= w_eff_cap);
            r_out_top_valid <= w_best_last.valid;
            r_out_tag       <= w_best_last.valid ? w_best_last.tag : '0;
            r_out_prio      <= w_best_last.valid ? w_best_last.prio : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_entry_count   = r_out_count;
    assign o_is_empty_flag = r_out_empty;
    assign o_is_full_flag  = r_out_full;
    assign o_top_valid     = r_out_top_valid;
    assign o_top_tag       = r_out_tag;
    assign o_top_priority  = r_out_prio;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds built depth");

    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (w_best_last.valid == (r_count != '0)))
        else $error("scan result disagrees with entry count");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_add_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted add did not grow the queue");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_top_valid == !o_is_empty_flag))
        else $error("top valid and empty flag disagree");
`endif

endmodule
